>>> sv/bpp_pkg.sv
// Package for the Boris particle pusher: shared types, codes and constants.
// No dependencies.
package bpp_pkg;

    localparam int unsigned DW = 32;

    // Configuration register indexes.
    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_BETA  = 2'd1;
    localparam logic [1:0] REG_DT    = 2'd2;
    localparam logic [1:0] REG_VONLY = 2'd3;

    // Datapath operations, one per controller step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,   // latch particle position, velocity and fields
        OP_KICK,   // k[i] = alpha*E[i], one component per step
        OP_HALF,   // m = sat(v + k)
        OP_CROSS,  // cross-term product a*b, then minus c*d
        OP_COEF,   // coefficient product, shift 24, saturate
        OP_POS     // x/y += dt*v
    } dp_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KICK,
        ST_HALF,
        ST_ROT,
        ST_POS,
        ST_DONE
    } state_t;

    // Command from controller to datapath.
    typedef struct packed {
        dp_op_t     op;
        logic [1:0] comp;   // component 0..2 (also 0/1 for x/y)
        logic       pass;   // 0: alpha pass (m->p), 1: beta pass (p->v)
        logic       phase;  // 0: first product, 1: second product
    } dp_cmd_t;

    function automatic logic signed [DW-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       return 32'sh7fffffff;
        else if (v < -66'sd2147483648) return 32'sh80000000;
        else                           return v[DW-1:0];
    endfunction

endpackage

>>> sv/boris_particle_push.sv
// Top level of the Boris particle pusher: controller, datapath, registers.
// Depends on bpp_pkg, bpp_ctrl, bpp_datapath.
//
//  channel   handshake          payload
//  input     start & !busy      pos, vel, efield, bfield, repeat_count
//  result    done (1 cycle)     new_pos_x/y, new_vel_x/y/z
//  config    cfg_valid&ready    cfg_index, cfg_data
//
// One shared 32x32 multiplier does all products. A push step runs the half
// kick, the rotation and the position advance; velocity-only mode runs one
// push step with no position advance. With zero push steps only the kick is
// computed. A new item is accepted only once the block is idle after done.
// Reset clears controller and configuration registers, not the datapath.
// Results cannot be stalled.
module boris_particle_push #(
    parameter int MAX_REPEAT = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] efield_x,
    input  logic signed [31:0] efield_y,
    input  logic signed [31:0] efield_z,
    input  logic signed [31:0] bfield_x,
    input  logic signed [31:0] bfield_y,
    input  logic signed [31:0] bfield_z,
    input  logic [4:0]         repeat_count,
    output logic               done,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    logic signed [31:0] alpha_reg, beta_reg, dt_reg;
    logic vonly_reg;
    bpp_pkg::dp_cmd_t cmd;
    logic signed [31:0] vel [3];
    logic signed [31:0] in_v [3], in_e [3], in_b [3];

    assign cfg_ready = 1'b1;

    // gather vector inputs
    assign in_v[0] = vel_x;
    assign in_v[1] = vel_y;
    assign in_v[2] = vel_z;
    assign in_e[0] = efield_x;
    assign in_e[1] = efield_y;
    assign in_e[2] = efield_z;
    assign in_b[0] = bfield_x;
    assign in_b[1] = bfield_y;
    assign in_b[2] = bfield_z;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
            beta_reg  <= '0;
            dt_reg    <= '0;
            vonly_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bpp_pkg::REG_ALPHA: alpha_reg <= cfg_data;
                bpp_pkg::REG_BETA:  beta_reg  <= cfg_data;
                bpp_pkg::REG_DT:    dt_reg    <= cfg_data;
                bpp_pkg::REG_VONLY: vonly_reg <= cfg_data[0];
                default:            vonly_reg <= vonly_reg;
            endcase
        end
    end

    bpp_ctrl #(.MAX_REPEAT(MAX_REPEAT)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .vonly        (vonly_reg),
        .repeat_count (repeat_count),
        .busy         (busy),
        .done         (done),
        .cmd          (cmd)
    );

    bpp_datapath u_dp (
        .clk   (clk),
        .alpha (alpha_reg),
        .beta  (beta_reg),
        .dt    (dt_reg),
        .cmd   (cmd),
        .in_px (pos_x),
        .in_py (pos_y),
        .in_v  (in_v),
        .in_e  (in_e),
        .in_b  (in_b),
        .px    (new_pos_x),
        .py    (new_pos_y),
        .vel   (vel)
    );

    assign new_vel_x = vel[0];
    assign new_vel_y = vel[1];
    assign new_vel_z = vel[2];
endmodule

>>> sv/bpp_datapath.sv
// Datapath of the Boris pusher: one shared 32x32 multiplier, accumulator
// and state registers. Depends on bpp_pkg.
module bpp_datapath (
    input  logic                 clk,
    input  logic signed [31:0]   alpha,
    input  logic signed [31:0]   beta,
    input  logic signed [31:0]   dt,
    input  bpp_pkg::dp_cmd_t     cmd,
    input  logic signed [31:0]   in_px,
    input  logic signed [31:0]   in_py,
    input  logic signed [31:0]   in_v [3],
    input  logic signed [31:0]   in_e [3],
    input  logic signed [31:0]   in_b [3],
    output logic signed [31:0]   px,
    output logic signed [31:0]   py,
    output logic signed [31:0]   vel [3]
);
    logic signed [31:0] px_reg, py_reg;
    logic signed [31:0] v_reg [3], k_reg [3], m_reg [3], p_reg [3], e_reg [3], b_reg [3];
    logic signed [65:0] acc_reg;
    logic signed [31:0] ct_reg;

    logic signed [31:0] op_a, op_b;
    logic signed [63:0] prod;
    logic signed [31:0] src [3];
    logic [1:0] i1, i2;
    logic signed [65:0] rnd;
    logic signed [31:0] coef_res;

    // rotating index helpers
    always_comb
    begin
        i1 = (cmd.comp == 2'd2) ? 2'd0 : cmd.comp + 2'd1;
        i2 = (cmd.comp == 2'd0) ? 2'd2 : cmd.comp - 2'd1;
    end

    // cross product source: m on the alpha pass, p on the beta pass
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            src[i] = cmd.pass ? p_reg[i] : m_reg[i];
    end

    // operand select for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.op)
            bpp_pkg::OP_KICK:
            begin
                op_a = alpha;
                op_b = e_reg[cmd.comp];
            end
            bpp_pkg::OP_CROSS:
            begin
                // c(a)[i] = a[i1]*b[i2] - a[i2]*b[i1]
                op_a = cmd.phase ? src[i2] : src[i1];
                op_b = cmd.phase ? b_reg[i1] : b_reg[i2];
            end
            bpp_pkg::OP_COEF:
            begin
                op_a = cmd.pass ? beta : alpha;
                op_b = ct_reg;
            end
            bpp_pkg::OP_POS:
            begin
                op_a = dt;
                op_b = v_reg[cmd.comp];
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod = op_a * op_b;
    // rounded Q8.24 coefficient product
    assign rnd = ($signed({{2{prod[63]}}, prod}) + 66'sd8388608) >>> 24;
    assign coef_res = bpp_pkg::sat32(rnd);

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            bpp_pkg::OP_LOAD:
            begin
                px_reg <= in_px;
                py_reg <= in_py;
                v_reg  <= in_v;
                e_reg  <= in_e;
                b_reg  <= in_b;
            end
            bpp_pkg::OP_KICK:
                k_reg[cmd.comp] <= coef_res;
            bpp_pkg::OP_HALF:
                for (int i = 0; i < 3; i++)
                    m_reg[i] <= bpp_pkg::sat32(66'(v_reg[i]) + 66'(k_reg[i]));
            bpp_pkg::OP_CROSS:
            begin
                if (!cmd.phase)
                    acc_reg <= 66'(prod);
                else
                    ct_reg <= bpp_pkg::sat32((acc_reg - 66'(prod) + 66'sd32768) >>> 16);
            end
            bpp_pkg::OP_COEF:
            begin
                if (!cmd.pass)
                    p_reg[cmd.comp] <= bpp_pkg::sat32(66'(m_reg[cmd.comp]) + 66'(coef_res));
                else
                    v_reg[cmd.comp] <= bpp_pkg::sat32(66'(m_reg[cmd.comp])
                        + 66'(k_reg[cmd.comp]) + 66'(coef_res));
            end
            bpp_pkg::OP_POS:
            begin
                if (cmd.comp == 2'd0)
                    px_reg <= bpp_pkg::sat32(66'(px_reg) + 66'(coef_res));
                else
                    py_reg <= bpp_pkg::sat32(66'(py_reg) + 66'(coef_res));
            end
            default:
            begin
            end
        endcase
    end

    assign px = px_reg;
    assign py = py_reg;
    assign vel = v_reg;
endmodule

>>> sv/bpp_ctrl.sv
// Controller of the Boris pusher: sequences the shared multiplier steps.
// Depends on bpp_pkg.
module bpp_ctrl #(
    parameter int MAX_REPEAT = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             vonly,
    input  logic [4:0]       repeat_count,
    output logic             busy,
    output logic             done,
    output bpp_pkg::dp_cmd_t cmd
);
    localparam int RW = $clog2(MAX_REPEAT + 1);

    bpp_pkg::state_t state_reg, state_next;
    logic [RW-1:0] reps_reg, reps_next;
    logic [1:0] comp_reg, comp_next;
    logic pass_reg, pass_next;
    logic phase_reg, phase_next;
    logic vonly_reg, vonly_next;
    logic [RW-1:0] req;

    // clamp requested repeat count
    always_comb
    begin
        if (32'(repeat_count) > MAX_REPEAT)
            req = RW'(MAX_REPEAT);
        else
            req = RW'(repeat_count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpp_pkg::ST_IDLE;
            reps_reg  <= '0;
            comp_reg  <= '0;
            pass_reg  <= 1'b0;
            phase_reg <= 1'b0;
            vonly_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reps_reg  <= reps_next;
            comp_reg  <= comp_next;
            pass_reg  <= pass_next;
            phase_reg <= phase_next;
            vonly_reg <= vonly_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        reps_next  = reps_reg;
        comp_next  = comp_reg;
        pass_next  = pass_reg;
        phase_next = phase_reg;
        vonly_next = vonly_reg;
        cmd        = '{op: bpp_pkg::OP_NONE, comp: comp_reg, pass: pass_reg, phase: phase_reg};
        busy       = (state_reg != bpp_pkg::ST_IDLE);
        done       = 1'b0;
        case (state_reg)
            bpp_pkg::ST_IDLE:
                if (start)
                begin
                    cmd.op     = bpp_pkg::OP_LOAD;
                    vonly_next = vonly;
                    reps_next  = vonly ? RW'(1) : req;
                    comp_next  = '0;
                    state_next = bpp_pkg::ST_KICK;
                end
            bpp_pkg::ST_KICK:
            begin
                cmd.op = bpp_pkg::OP_KICK;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = '0;
                    state_next = (reps_reg == '0) ? bpp_pkg::ST_DONE : bpp_pkg::ST_HALF;
                end
                else
                    comp_next = comp_reg + 2'd1;
            end
            bpp_pkg::ST_HALF:
            begin
                cmd.op     = bpp_pkg::OP_HALF;
                comp_next  = '0;
                pass_next  = 1'b0;
                phase_next = 1'b0;
                state_next = bpp_pkg::ST_ROT;
            end
            bpp_pkg::ST_ROT:
            begin
                // per component: two products, then the coefficient
                cmd.op = bpp_pkg::OP_CROSS;
                if (!phase_reg)
                    phase_next = 1'b1;
                else
                begin
                    phase_next = 1'b0;
                    state_next = bpp_pkg::ST_POS;
                end
            end
            bpp_pkg::ST_POS:
            begin
                // despite its name, this state applies the coefficient for the current component
                cmd.op = bpp_pkg::OP_COEF;
                if (comp_reg != 2'd2)
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = bpp_pkg::ST_ROT;
                end
                else if (!pass_reg)
                begin
                    comp_next  = '0;
                    pass_next  = 1'b1;
                    state_next = bpp_pkg::ST_ROT;
                end
                else
                begin
                    comp_next  = '0;
                    pass_next  = 1'b0;
                    reps_next  = reps_reg - RW'(1);
                    state_next = bpp_pkg::ST_DONE;
                    if (!vonly_reg)
                    begin
                        phase_next = 1'b1; // flag: position advance pending
                        state_next = bpp_pkg::ST_KICK;
                        comp_next  = 2'd3;
                    end
                end
            end
            bpp_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = bpp_pkg::ST_IDLE;
            end
            default:
                state_next = bpp_pkg::ST_IDLE;
        endcase
        // position advance: reuse ST_KICK with comp 3 marker
        if (state_reg == bpp_pkg::ST_KICK && comp_reg == 2'd3)
        begin
            cmd.op   = bpp_pkg::OP_POS;
            cmd.comp = phase_reg ? 2'd0 : 2'd1;
            if (phase_reg)
            begin
                phase_next = 1'b0;
                comp_next  = 2'd3;
                state_next = bpp_pkg::ST_KICK;
            end
            else
            begin
                comp_next  = '0;
                state_next = (reps_reg == '0) ? bpp_pkg::ST_DONE : bpp_pkg::ST_HALF;
            end
        end
    end
endmodule

>>> sv/bpp_checker.sv
// Port-level checker for the Boris pusher, bound to the top level.
// Depends on boris_particle_push ports only.
module bpp_props (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);
    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done longer than one cycle");
    // result only while busy
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done while idle");
    // accepted item makes the block busy
    a_accept: assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accept without busy");
    // block frees up after a result
    a_free: assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("busy after result");
endmodule

bind boris_particle_push bpp_props u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
